FILE: rtl/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types, constants and helper functions for the block transposition
// cipher core.
// ----------------------------------------------------------------------------
package btc_pkg;

   localparam int STORE_DEPTH = 8;
   localparam int ADDR_W      = 3;
   localparam int CHAR_W      = 8;
   localparam int PERM_W      = 24;
   localparam int COUNT_W     = 4;

   localparam logic [PERM_W-1:0] PERM_RESET = 24'hFAC688;

   localparam logic [CHAR_W-1:0] PAD_CHAR    = 8'd88;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
   localparam logic [CHAR_W-1:0] LOWER_BELOW = 8'd96;
   localparam logic [CHAR_W-1:0] LOWER_ABOVE = 8'd123;
   localparam logic [CHAR_W-1:0] UPPER_BELOW = 8'd64;
   localparam logic [CHAR_W-1:0] UPPER_ABOVE = 8'd91;

   localparam logic FUNC_TEXT  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_READ,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   function automatic logic is_lower(input logic [CHAR_W-1:0] c);
      return (c > LOWER_BELOW) && (c < LOWER_ABOVE);
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c > UPPER_BELOW) && (c < UPPER_ABOVE)) || is_lower(c);
   endfunction

   function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
      return is_lower(c) ? (c - CASE_OFFSET) : c;
   endfunction

endpackage

FILE: rtl/block_transposition_cipher_core.sv
// ----------------------------------------------------------------------------
// block_transposition_cipher_core
// Keyed block transposition of an ASCII letter stream with padding on flush.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_func, req_char_code
//   rsp_      out        rsp_valid/rsp_stall   rsp_cipher_char, rsp_block_last
//   csr_      in         csr_wr_en             csr_wr_data (permutation)
//
// A text or flush transaction is accepted while no block is being emitted.
// Each emitted character takes one memory read and then one output register
// load, and req_stall stays high while a block is emitted, also while the
// output is stalled. Reset is synchronous, clears the sequencer and the
// letter count and loads the reset permutation; the letter memory is not
// cleared.
// ----------------------------------------------------------------------------
module block_transposition_cipher_core #(
   parameter int KEY_LEN = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [btc_pkg::CHAR_W-1:0]             req_char_code,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [btc_pkg::CHAR_W-1:0]             rsp_cipher_char,
   output logic                                   rsp_block_last,
   input  logic                                   csr_wr_en,
   input  logic [btc_pkg::PERM_W-1:0]             csr_wr_data
);
   import btc_pkg::*;

   localparam int BLOCK_N = (KEY_LEN > STORE_DEPTH) ? STORE_DEPTH : KEY_LEN;

   logic [PERM_W-1:0] perm_ff, perm_in;
   mem_req_type       mem_req;
   logic [CHAR_W-1:0] mem_rd_data;

   always_comb begin
      perm_in = csr_wr_en ? csr_wr_data : perm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_ff <= PERM_RESET;
      end else begin
         perm_ff <= perm_in;
      end
   end

   btc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   btc_ctrl #(
      .BLOCK_N (BLOCK_N)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .perm            (perm_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .mem_req         (mem_req),
      .mem_rd_data     (mem_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cipher_char (rsp_cipher_char),
      .rsp_block_last  (rsp_block_last)
   );

endmodule

FILE: rtl/btc_store.sv
// ----------------------------------------------------------------------------
// btc_store
// Block letter memory indexed by arrival index, one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module btc_store (
   input  logic                                   clock,
   input  btc_pkg::mem_req_type                   mem_req,
   output logic [btc_pkg::CHAR_W-1:0]             rd_data
);
   import btc_pkg::*;

   logic [CHAR_W-1:0] mem_ff [STORE_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/btc_ctrl.sv
// ----------------------------------------------------------------------------
// btc_ctrl
// Sequencer that filters and stores letters, then walks the output positions,
// finds the source index of each through the permutation and emits it.
// ----------------------------------------------------------------------------
module btc_ctrl #(
   parameter int BLOCK_N = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [btc_pkg::PERM_W-1:0]             perm,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic [btc_pkg::CHAR_W-1:0]             req_char_code,
   output btc_pkg::mem_req_type                   mem_req,
   input  logic [btc_pkg::CHAR_W-1:0]             mem_rd_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [btc_pkg::CHAR_W-1:0]             rsp_cipher_char,
   output logic                                   rsp_block_last
);
   import btc_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BLOCK_N);
   localparam logic [ADDR_W-1:0]  LAST_POS   = ADDR_W'(BLOCK_N - 1);

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic               hit_ff, hit_in;
   logic [ADDR_W-1:0]  src_ff, src_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic               hit_s;
   logic [ADDR_W-1:0]  src_s;

   always_comb begin
      hit_s = 1'b0;
      src_s = '0;
      for (int i = 0; i < BLOCK_N; i++) begin
         if (perm[3*i +: 3] == pos_ff) begin
            hit_s = 1'b1;
            src_s = ADDR_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      src_ff  <= src_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      src_in       = src_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      mem_req      = '0;
      req_stall    = (state_ff != ST_RUN);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_RUN: begin
            if (req_valid) begin
               if (req_func == FUNC_FLUSH) begin
                  if (count_ff != '0) begin
                     state_in = ST_READ;
                     pos_in   = '0;
                  end
               end else if (is_letter(req_char_code)) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = count_ff[ADDR_W-1:0];
                  mem_req.wr_data = to_upper(req_char_code);
                  count_in        = count_ff + COUNT_W'(1);
                  if (count_in == FULL_COUNT) begin
                     state_in = ST_READ;
                     pos_in   = '0;
                  end
               end
            end
         end
         ST_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = src_s;
            hit_in          = hit_s;
            src_in          = src_s;
            state_in        = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (!hit_ff) begin
                  char_in = '0;
               end else if ({1'b0, src_ff} >= count_ff) begin
                  char_in = PAD_CHAR;
               end else begin
                  char_in = mem_rd_data;
               end
               last_in = (pos_ff == LAST_POS);
               if (pos_ff == LAST_POS) begin
                  state_in = ST_RUN;
                  count_in = '0;
               end else begin
                  pos_in   = pos_ff + ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_char = char_ff;
   assign rsp_block_last  = last_ff;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for block_transposition_cipher_core. A scoreboard
// predicts every cipher character and block marker from the accepted
// transactions and the current permutation, then checks the output channel
// in order. Stimulus runs a directed pass and then several random phases
// under different permutations, with random idling on the request side and random response stalls.
// ----------------------------------------------------------------------------
module tb;
   import btc_pkg::*;

   localparam int          BLOCK_LEN    = 8;
   localparam int          BLOCK_N      = (BLOCK_LEN > STORE_DEPTH) ? STORE_DEPTH : BLOCK_LEN;
   localparam int          DRAIN_CYCLES = 2 * BLOCK_LEN + 8;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          PHASE_ITEMS  = 73;
   localparam int          LONG_HOLD    = 180;
   localparam logic [PERM_W-1:0] PERM_REVERSE = 24'h053977;
   localparam logic [PERM_W-1:0] PERM_ZEROS   = 24'h000000;
   localparam logic [PERM_W-1:0] PERM_ONES    = 24'hFFFFFF;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } cipher_out_type;

   class cipher_scoreboard_type;
      logic [CHAR_W-1:0] letters [STORE_DEPTH];
      int unsigned       held;
      logic [PERM_W-1:0] perm;
      cipher_out_type    expected_q [$];
      int unsigned       mismatches;
      int unsigned       items_seen;
      int unsigned       chars_seen;
      int unsigned       blocks_seen;
      int unsigned       settings;

      function void reset_state();
         held        = 0;
         perm        = PERM_RESET;
         mismatches  = 0;
         items_seen  = 0;
         chars_seen  = 0;
         blocks_seen = 0;
         settings    = 1;
      endfunction

      function void set_perm(input logic [PERM_W-1:0] v);
         perm     = v;
         settings = settings + 1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void emit_block();
         logic [CHAR_W-1:0] placed [STORE_DEPTH];
         cipher_out_type    e;
         int unsigned       tgt;
         for (int i = 0; i < STORE_DEPTH; i++) placed[i] = '0;
         for (int i = 0; i < BLOCK_N; i++) begin
            tgt = 32'(perm[3*i +: 3]);
            if (tgt < BLOCK_N) placed[tgt] = letters[i];
         end
         for (int i = 0; i < BLOCK_N; i++) begin
            e.ch   = placed[i];
            e.last = (i == BLOCK_N - 1);
            expected_q.push_back(e);
         end
         held        = 0;
         blocks_seen = blocks_seen + 1;
      endfunction

      function void note_item(input logic f, input logic [CHAR_W-1:0] c);
         logic upper;
         logic lower;
         upper      = (c > UPPER_BELOW) && (c < UPPER_ABOVE);
         lower      = (c > LOWER_BELOW) && (c < LOWER_ABOVE);
         items_seen = items_seen + 1;
         if (held >= BLOCK_N) held = 0;
         if (f == FUNC_FLUSH) begin
            if (held != 0) begin
               for (int i = held; i < BLOCK_N; i++) letters[i] = PAD_CHAR;
               emit_block();
            end
         end else if (upper || lower) begin
            letters[held] = lower ? (c - CASE_OFFSET) : c;
            held          = held + 1;
            if (held >= BLOCK_N) emit_block();
         end
      endfunction

      function void check_result(input logic [CHAR_W-1:0] ch, input logic last);
         cipher_out_type e;
         chars_seen = chars_seen + 1;
         if (expected_q.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("Unexpected output transaction: char %02h last %0b", ch, last);
         end else begin
            e = expected_q.pop_front();
            if (ch !== e.ch || last !== e.last) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("Mismatch: expected char %02h last %0b, got char %02h last %0b",
                           e.ch, e.last, ch, last);
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_func;
   logic [CHAR_W-1:0] req_char_code;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [CHAR_W-1:0] rsp_cipher_char;
   logic              rsp_block_last;
   logic              csr_wr_en;
   logic [PERM_W-1:0] csr_wr_data;

   cipher_scoreboard_type sb;
   int unsigned       idle_cycles;
   bit                tx_burst;
   bit                rx_quiet;
   bit                hold_req;
   int unsigned       stall_left;

   block_transposition_cipher_core #(
      .KEY_LEN(BLOCK_LEN)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cipher_char(rsp_cipher_char),
      .rsp_block_last (rsp_block_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_func, req_char_code);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_cipher_char, rsp_block_last);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned r;
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left = stall_left - 1;
         end else if (rx_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall  <= 1'b1;
               stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            end
         end
      end
   end

   function automatic int unsigned tx_gap();
      int unsigned r;
      if (tx_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic logic [PERM_W-1:0] shuffled_perm();
      int unsigned       slot [BLOCK_N];
      int unsigned       j;
      int unsigned       tmp;
      logic [PERM_W-1:0] v;
      v = '0;
      for (int i = 0; i < BLOCK_N; i++) slot[i] = i;
      for (int i = BLOCK_N - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         tmp     = slot[i];
         slot[i] = slot[j];
         slot[j] = tmp;
      end
      for (int i = 0; i < BLOCK_N; i++) v[3*i +: 3] = 3'(slot[i]);
      return v;
   endfunction

   task automatic send_item(input logic f, input logic [CHAR_W-1:0] c);
      int unsigned gap;
      gap = tx_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_char_code <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(FUNC_TEXT, s[i]);
   endtask

   task automatic send_random();
      int unsigned       r;
      logic [CHAR_W-1:0] c;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         c = CHAR_W'($urandom_range(8'h41, 8'h5A));
         if ($urandom_range(0, 1)) c = c + CASE_OFFSET;
         send_item(FUNC_TEXT, c);
      end else if (r < 95) begin
         send_item(FUNC_TEXT, CHAR_W'($urandom_range(0, 255)));
      end else begin
         send_item(FUNC_FLUSH, CHAR_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic quiesce();
      wait_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_permutation(input logic [PERM_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      sb.set_perm(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [PERM_W-1:0] phase_perm [6];
      sb            = new();
      sb.reset_state();
      idle_cycles   = 0;
      tx_burst      = 1'b0;
      rx_quiet      = 1'b0;
      hold_req      = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_TEXT;
      req_char_code = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("AZaz@[`{");
      send_item(FUNC_TEXT, 8'h00);
      send_item(FUNC_TEXT, 8'hFF);
      send_item(FUNC_FLUSH, 8'h00);
      send_item(FUNC_FLUSH, 8'hFF);
      send_text("CipherOk");
      send_item(FUNC_FLUSH, 8'h41);
      send_text("qWm");
      send_item(FUNC_FLUSH, 8'h7A);
      quiesce();

      phase_perm[0] = PERM_REVERSE;
      phase_perm[1] = PERM_ZEROS;
      phase_perm[2] = PERM_ONES;
      phase_perm[3] = shuffled_perm();
      phase_perm[4] = PERM_W'($urandom_range(0, 24'hFFFFFF));
      phase_perm[5] = shuffled_perm();

      for (int p = 0; p < 6; p++) begin
         tx_burst = (p == 2) || (p == 4);
         rx_quiet = (p == 4);
         set_permutation(phase_perm[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 20) hold_req = 1'b1;
            if (p == 3 && n == 40) wait_results();
            send_random();
         end
         send_item(FUNC_FLUSH, CHAR_W'($urandom_range(0, 255)));
         quiesce();
      end

      $display("Run covered %0d input transactions and %0d output characters in %0d blocks,",
               sb.items_seen, sb.chars_seen, sb.blocks_seen);
      $display("over %0d permutation settings including all-equal and reversed targets.",
               sb.settings);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results still expected", sb.mismatches, sb.pending());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/btc_pkg.sv
rtl/btc_store.sv
rtl/btc_ctrl.sv
rtl/block_transposition_cipher_core.sv
dv/tb.sv
